/* rtl/dld_pkg.sv */
// Package for the Damerau-Levenshtein distance engine: sizes, modes and states.
// No dependencies.
`default_nettype none
package dld_pkg;
    localparam int MaxLenDefault   = 32;
    localparam int AlphabetDefault = 256;

    localparam logic [1:0] MODE_APPEND_A = 2'd0;
    localparam logic [1:0] MODE_APPEND_B = 2'd1;
    localparam logic [1:0] MODE_COMPUTE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_BORDER,
        S_ROW,
        S_RD,
        S_RD2,
        S_RD3,
        S_CALC,
        S_ROW_END,
        S_FIN_RD,
        S_FIN,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

/* rtl/dld_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module dld_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/damerau_levenshtein_distance.sv */
// Top level of the unrestricted Damerau-Levenshtein distance engine.
// Depends on dld_pkg and dld_ram.
`default_nettype none
// Each append word is written straight into its word memory. A compute word
// clears the last-row table, writes the matrix border, then fills la*lb cells
// through the single-read-port cost memory, each cell in the states S_RD,
// S_RD2, S_RD3 and S_CALC, with S_ROW and S_ROW_END around each row; then
// S_FIN_RD and S_FIN fetch the result and S_OUT presents it. One item is in
// work at a time; the result sits in an output register and the next word is
// taken once it is delivered.
module damerau_levenshtein_distance
    import dld_pkg::*;
#(
    parameter int MAX_LEN       = MaxLenDefault,
    parameter int ALPHABET_SIZE = AlphabetDefault
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_symbol,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [5:0]      o_distance,
    output logic            o_overflow
);
    localparam int Dim  = MAX_LEN + 2;
    localparam int Cells = Dim * Dim;
    localparam int LW   = $clog2(MAX_LEN + 1);        // length width
    localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW   = $clog2(Cells);
    localparam int DW   = $clog2(Dim);
    localparam int VW   = $clog2(2 * MAX_LEN + 2);    // cost value width
    localparam int TW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    t_state r_state, n_state;
    logic [LW-1:0] r_len_a, r_len_b;
    logic          r_ovf;
    logic [DW-1:0] r_i, r_j, r_k, r_l, r_last_col;
    logic [TW:0]   r_clr;
    logic [7:0]    r_sa, r_sb;
    logic [VW-1:0] r_c0, r_c1, r_c2;
    logic [5:0]    r_dist;
    logic          r_dovf;

    // memories
    logic          a_we, b_we, c_we, t_we;
    logic [AW-1:0] a_wa, a_ra, b_wa, b_ra;
    logic [7:0]    a_rd, b_rd;
    logic [CW-1:0] c_wa, c_ra;
    logic [VW-1:0] c_wd, c_rd;
    logic [TW-1:0] t_wa, t_ra;
    logic [DW-1:0] t_wd, t_rd;

    dld_ram #(.Width(8), .Depth(MAX_LEN)) u_word_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_wa), .i_wdata(i_symbol),
        .i_raddr(a_ra), .o_rdata(a_rd));
    dld_ram #(.Width(8), .Depth(MAX_LEN)) u_word_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_wa), .i_wdata(i_symbol),
        .i_raddr(b_ra), .o_rdata(b_rd));
    dld_ram #(.Width(VW), .Depth(Cells)) u_cost (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_raddr(c_ra), .o_rdata(c_rd));
    dld_ram #(.Width(DW), .Depth(ALPHABET_SIZE)) u_last_row (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd));

    function automatic logic [CW-1:0] cell_addr(input logic [DW-1:0] r,
                                                input logic [DW-1:0] c);
        logic [CW+DW:0] p;
        p = CW'(r) * CW'(Dim) + CW'(c);
        return p[CW-1:0];
    endfunction

    logic accept_in, accept_out;
    logic [VW-1:0] inf;
    logic [DW-1:0] la_d, lb_d;
    logic sb_in;
    logic [DW-1:0] k_eff;
    logic [VW+1:0] best, trans, t_up, t_left, t_diag;
    logic          sym_eq;

    assign accept_in  = i_valid && o_ready;
    assign accept_out = o_valid && i_ready;
    assign la_d = DW'(r_len_a);
    assign lb_d = DW'(r_len_b);
    assign inf  = VW'(r_len_a) + VW'(r_len_b);
    assign sb_in = ({1'b0, r_sb} < 9'(ALPHABET_SIZE));
    assign k_eff = sb_in ? t_rd : '0;
    assign sym_eq = (r_sa == r_sb);

    // cost of current cell: c0 = diag, c1 = left, c2 = up, c_rd = transposition base
    always_comb begin
        t_diag = (VW+2)'(r_c0) + (sym_eq ? '0 : (VW+2)'(1));
        t_left = (VW+2)'(r_c1) + (VW+2)'(1);
        t_up   = (VW+2)'(r_c2) + (VW+2)'(1);
        trans  = (VW+2)'(c_rd) + (VW+2)'(r_i - r_k - 1'b1) + (VW+2)'(1)
                 + (VW+2)'(r_j - r_l - 1'b1);
        best = t_diag;
        if (t_left < best) best = t_left;
        if (t_up < best) best = t_up;
        if (trans < best) best = trans;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (accept_in && i_mode == MODE_COMPUTE) n_state = S_CLEAR;
            S_CLEAR:   if (r_clr == (TW+1)'(ALPHABET_SIZE - 1)) n_state = S_BORDER;
            S_BORDER:  if (r_i == DW'(MAX_LEN + 1) && r_j == DW'(MAX_LEN + 1))
                           n_state = S_ROW;
            S_ROW:     n_state = (r_i > la_d) ? S_FIN_RD : S_RD;
            S_RD:      n_state = (r_j > lb_d) ? S_ROW_END : S_RD2;
            S_RD2:     n_state = S_RD3;
            S_RD3:     n_state = S_CALC;
            S_CALC:    n_state = S_RD;
            S_ROW_END: n_state = S_ROW;
            S_FIN_RD:  n_state = S_FIN;
            S_FIN:     n_state = S_OUT;
            S_OUT:     if (accept_out) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory ports and handshake
    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_OUT);
        o_distance = r_dist;
        o_overflow = r_dovf;
        a_we = accept_in && i_mode == MODE_APPEND_A && r_len_a < LW'(MAX_LEN);
        b_we = accept_in && i_mode == MODE_APPEND_B && r_len_b < LW'(MAX_LEN);
        a_wa = AW'(r_len_a);
        b_wa = AW'(r_len_b);
        a_ra = AW'(r_i - 1'b1);
        b_ra = AW'(r_j - 1'b1);
        t_we = 1'b0;
        t_wa = r_clr[TW-1:0];
        t_wd = '0;
        t_ra = TW'(b_rd);
        c_we = 1'b0;
        c_wa = '0;
        c_wd = '0;
        c_ra = '0;
        unique case (r_state)
            S_CLEAR: t_we = 1'b1;
            S_BORDER: begin
                // r_i walks column entries, r_j row entries, both over 0..MAX_LEN+1
                c_we = 1'b1;
                if (r_i == 0 && r_j == 0) begin
                    c_wa = '0;
                    c_wd = inf;
                end else if (r_i != 0) begin
                    c_wa = cell_addr(r_i, DW'(r_j[0]));
                    c_wd = r_j[0] ? VW'(r_i - 1'b1) : inf;
                end else begin
                    c_wa = cell_addr(DW'(r_l[0]), r_j);
                    c_wd = r_l[0] ? VW'(r_j - 1'b1) : inf;
                end
            end
            S_RD:  c_ra = cell_addr(r_i, r_j);                 // diag M[i][j]
            S_RD2: c_ra = cell_addr(r_i, r_j + 1'b1);          // up M[i][j+1]
            S_RD3: begin
                c_ra = cell_addr(k_eff, r_last_col);         // transposition base
            end
            S_CALC: begin
                c_we = 1'b1;
                c_wa = cell_addr(r_i + 1'b1, r_j + 1'b1);
                c_wd = VW'(best);
            end
            S_ROW_END: begin
                t_we = ({1'b0, r_sa} < 9'(ALPHABET_SIZE));
                t_wa = TW'(r_sa);
                t_wd = r_i;
            end
            S_FIN_RD: c_ra = cell_addr(la_d + 1'b1, lb_d + 1'b1);
            default: ;
        endcase
    end

    // Cell (i,j) uses matrix index (i+1,j+1); r_i holds i, r_j holds j in the row loop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len_a <= '0;
            r_len_b <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept_in) begin
                if (i_mode == MODE_APPEND_A) begin
                    if (r_len_a < LW'(MAX_LEN)) r_len_a <= r_len_a + 1'b1;
                    else r_ovf <= 1'b1;
                end else if (i_mode == MODE_APPEND_B) begin
                    if (r_len_b < LW'(MAX_LEN)) r_len_b <= r_len_b + 1'b1;
                    else r_ovf <= 1'b1;
                end
            end
            if (r_state == S_FIN) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_clr <= '0;
                r_i   <= '0;
                r_j   <= '0;
                r_l   <= '0;
            end
            S_CLEAR: r_clr <= r_clr + 1'b1;
            S_BORDER: begin
                // sweep column border (i=1..MAX_LEN+1, two entries each), then row border
                if (r_i != 0 || (r_j == 0 && r_l == 0)) begin
                    if (r_i == 0) begin
                        r_i <= DW'(1);
                    end else if (r_j == 0) begin
                        r_j <= DW'(1);
                    end else if (r_i == DW'(MAX_LEN + 1)) begin
                        r_i <= '0;
                        r_j <= DW'(1);
                        r_l <= '0;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_j <= '0;
                    end
                    if (r_i == 0) r_l <= DW'(1);
                end else begin
                    if (r_l[0] == 1'b0) begin
                        r_l <= DW'(1);
                    end else if (r_j == DW'(MAX_LEN + 1)) begin
                        r_i <= DW'(MAX_LEN + 1);
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_l <= '0;
                    end
                end
                if (n_state == S_ROW) begin
                    r_i <= DW'(1);
                    r_j <= DW'(1);
                end
            end
            S_ROW: begin
                r_j <= DW'(1);
                r_last_col <= '0;
                r_c1 <= VW'(r_i);     // M[i+1][1] = i
            end
            S_RD2: begin
                r_sa <= a_rd;
                r_sb <= b_rd;
                r_c0 <= c_rd;
            end
            S_RD3: begin
                r_c2 <= c_rd;
                r_k  <= k_eff;
                r_l  <= r_last_col;
            end
            S_CALC: begin
                r_c1 <= VW'(best);
                if (sym_eq) r_last_col <= r_j;
                r_j <= r_j + 1'b1;
            end
            S_ROW_END: r_i <= r_i + 1'b1;
            S_FIN: begin
                r_dist <= (c_rd > VW'(63)) ? 6'd63 : 6'(c_rd);
                r_dovf <= r_ovf;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
